// ----- rtl/lrc_pkg.sv -----
package lrc_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
  localparam logic [31:0] START_OFFSET_RST = 32'd16;
  localparam logic [23:0] LENGTH_LIMIT_RST = 24'd65548;
  localparam logic [31:0] MAGIC_RST = 32'h43454C52;
  localparam logic [3:0] HEADER_BYTES = 4'd12;
  localparam logic [1:0] FOOTER_LAST = 2'd3;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_MAGIC = 2'd2;
  localparam logic [1:0] REG_ORDER = 2'd3;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_BAD_HDR  = 3'd2,
    KIND_CRC_ERR  = 3'd3,
    KIND_TRUNC    = 3'd4,
    KIND_SIZE     = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [23:0] record_length;
    logic [31:0] good_offset;
    logic        end_of_log;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic logic [31:0] take_byte(input logic [31:0] acc, input logic [7:0] b,
                                            input logic le);
    if (le) begin
      return {b, acc[31:8]};
    end
    return {acc[23:0], b};
  endfunction

endpackage

// ----- rtl/lrc_if.sv -----
interface lrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] log_byte;
  logic       last_of_log;
  modport source(output valid, log_byte, last_of_log, input ready);
  modport sink(input valid, log_byte, last_of_log, output ready);
endinterface

interface lrc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [23:0] record_length;
  logic [31:0] good_offset;
  logic        end_of_log;
  modport source(output valid, kind, data_byte, record_length, good_offset, end_of_log,
                 input ready);
  modport sink(input valid, kind, data_byte, record_length, good_offset, end_of_log,
               output ready);
endinterface

interface lrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/lrc_front.sv -----
module lrc_front #(
  parameter int OFFSET_BITS = lrc_pkg::OFFSET_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  lrc_in_if.sink          in_ch,
  lrc_cfg_if.sink         cfg_ch,
  input  logic            q_full,
  output logic            q_push,
  output lrc_pkg::result_t q_data
);

  typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_FOOTER} phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [23:0]            count_r, count_nxt;
  logic [31:0]            magic_r, magic_nxt;
  logic [31:0]            len_r, len_nxt;
  logic [31:0]            hcrc_r, hcrc_nxt;
  logic [31:0]            crc_r, crc_nxt;
  logic [31:0]            foot_r, foot_nxt;
  logic [OFFSET_BITS-1:0] cur_r, cur_nxt;
  logic [OFFSET_BITS-1:0] good_r, good_nxt;
  logic                   halted_r, halted_nxt;
  logic [23:0]            limit_r;
  logic [31:0]            mword_r;
  logic                   order_r;

  logic                   fire;
  logic                   emit;
  logic                   len_known;
  lrc_pkg::kind_t         kind;
  logic [7:0]             data;
  logic [7:0]             b;
  logic [31:0]            ma, la, ha, fa, crc_b, fo_b;
  logic [23:0]            cnt1;
  logic                   cfg_start;
  logic [OFFSET_BITS-1:0] cfg_off;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign fire = in_ch.valid && in_ch.ready;
  assign b = in_ch.log_byte;
  assign cfg_start = cfg_ch.valid && cfg_ch.index == lrc_pkg::REG_START;
  assign cfg_off = OFFSET_BITS'({16'd0, cfg_ch.data});

  always_comb begin
    phase_nxt = phase_r; count_nxt = count_r; magic_nxt = magic_r; len_nxt = len_r;
    hcrc_nxt = hcrc_r; crc_nxt = crc_r; foot_nxt = foot_r; cur_nxt = cur_r;
    good_nxt = good_r; halted_nxt = halted_r;
    emit = 1'b0; len_known = 1'b0; kind = lrc_pkg::KIND_PAYLOAD; data = 8'd0;
    ma = magic_r; la = len_r; ha = hcrc_r; fa = foot_r;
    crc_b = lrc_pkg::crc_byte(crc_r, b);
    fo_b = lrc_pkg::take_byte(foot_r, b, order_r);
    cnt1 = count_r + 24'd1;
    if (fire && !halted_r) begin
      if (cur_r == {OFFSET_BITS{1'b1}}) begin
        emit = 1'b1; kind = lrc_pkg::KIND_SIZE; halted_nxt = 1'b1;
      end else begin
        cur_nxt = cur_r + OFFSET_BITS'(1);
        case (phase_r)
          PH_HEADER: begin
            if (count_r == 24'd0) begin
              ma = 32'd0; la = 32'd0; ha = 32'd0;
            end
            if (count_r < 24'd8) begin
              crc_nxt = crc_b;
            end
            if (count_r < 24'd4) begin
              ma = lrc_pkg::take_byte(ma, b, order_r);
            end else if (count_r < 24'd8) begin
              la = lrc_pkg::take_byte(la, b, order_r);
            end else begin
              ha = lrc_pkg::take_byte(ha, b, order_r);
            end
            magic_nxt = ma; len_nxt = la; hcrc_nxt = ha;
            count_nxt = cnt1;
            if (cnt1 >= {20'd0, lrc_pkg::HEADER_BYTES}) begin
              if (ma != mword_r || (crc_r ^ lrc_pkg::CRC_ONES) != ha ||
                  la > {8'd0, limit_r}) begin
                emit = 1'b1; kind = lrc_pkg::KIND_BAD_HDR; len_known = 1'b1;
                halted_nxt = 1'b1;
              end else begin
                phase_nxt = (la != 32'd0) ? PH_PAYLOAD : PH_FOOTER;
                count_nxt = 24'd0; crc_nxt = lrc_pkg::CRC_ONES; foot_nxt = 32'd0;
              end
            end
          end
          PH_PAYLOAD: begin
            crc_nxt = crc_b; count_nxt = cnt1;
            emit = 1'b1; kind = lrc_pkg::KIND_PAYLOAD; data = b;
            if ({8'd0, cnt1} >= len_r) begin
              phase_nxt = PH_FOOTER; count_nxt = 24'd0; foot_nxt = 32'd0;
            end
          end
          default: begin
            foot_nxt = fo_b; count_nxt = cnt1;
            if (count_r[1:0] == lrc_pkg::FOOTER_LAST) begin
              emit = 1'b1; len_known = 1'b1;
              if (fo_b == (crc_r ^ lrc_pkg::CRC_ONES)) begin
                kind = lrc_pkg::KIND_GOOD; good_nxt = cur_nxt;
                phase_nxt = PH_HEADER; count_nxt = 24'd0; crc_nxt = lrc_pkg::CRC_ONES;
              end else begin
                kind = lrc_pkg::KIND_CRC_ERR; halted_nxt = 1'b1;
              end
            end
          end
        endcase
      end
      if (in_ch.last_of_log) begin
        if (!emit || kind == lrc_pkg::KIND_PAYLOAD) begin
          kind = lrc_pkg::KIND_TRUNC; data = 8'd0;
        end
        emit = 1'b1; halted_nxt = 1'b1;
      end
      if (phase_nxt != PH_HEADER) begin
        len_known = 1'b1;
      end
    end
  end

  assign q_push = emit;
  always_comb begin
    q_data.kind          = kind;
    q_data.data_byte     = data;
    q_data.record_length = len_known ? len_nxt[23:0] : 24'd0;
    q_data.good_offset   = 32'(good_nxt);
    q_data.end_of_log    = in_ch.last_of_log;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER; count_r <= '0; magic_r <= '0; len_r <= '0; hcrc_r <= '0;
      crc_r <= lrc_pkg::CRC_ONES; foot_r <= '0;
      cur_r <= OFFSET_BITS'(lrc_pkg::START_OFFSET_RST);
      good_r <= OFFSET_BITS'(lrc_pkg::START_OFFSET_RST);
      halted_r <= 1'b0;
      limit_r <= lrc_pkg::LENGTH_LIMIT_RST;
      mword_r <= lrc_pkg::MAGIC_RST; order_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; count_r <= count_nxt; magic_r <= magic_nxt; len_r <= len_nxt;
      hcrc_r <= hcrc_nxt; crc_r <= crc_nxt; foot_r <= foot_nxt;
      cur_r <= cfg_start ? cfg_off : cur_nxt;
      good_r <= cfg_start ? cfg_off : good_nxt;
      halted_r <= halted_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          lrc_pkg::REG_LIMIT: limit_r <= cfg_ch.data[23:0];
          lrc_pkg::REG_MAGIC: mword_r <= cfg_ch.data;
          lrc_pkg::REG_ORDER: order_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/lrc_queue.sv -----
module lrc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lrc_pkg::result_t push_data,
  output logic             full,
  lrc_out_if.source        out_ch
);

  lrc_pkg::result_t mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             pop;

  assign full = cnt_r == 2'd2 && !out_ch.ready;
  assign pop = out_ch.valid && out_ch.ready;
  assign out_ch.valid = cnt_r != 2'd0;
  assign out_ch.kind = mem_r[rp_r].kind;
  assign out_ch.data_byte = mem_r[rp_r].data_byte;
  assign out_ch.record_length = mem_r[rp_r].record_length;
  assign out_ch.good_offset = mem_r[rp_r].good_offset;
  assign out_ch.end_of_log = mem_r[rp_r].end_of_log;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/log_record_checker_crc32_unit.sv -----
// Channel | Dir | Beat contents
// in_     | in  | log_byte, last_of_log
// out_    | out | kind, data_byte, record_length, good_offset, end_of_log
// cfg_    | in  | index, data (register write)
// One byte is accepted per cycle while the queue is not full; each result is registered in the queue.
// The CRC step is one combinational byte update in the front stage.
// A two-entry queue holds results, so input stalls only when it is full and not draining.
// Reset is synchronous; there is no clearing pass.
module log_record_checker_crc32_unit #(
  parameter int OFFSET_BITS = lrc_pkg::OFFSET_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lrc_in_if.sink    in_ch,
  lrc_out_if.source out_ch,
  lrc_cfg_if.sink   cfg_ch
);

  logic             q_full, q_push;
  lrc_pkg::result_t q_data;

  lrc_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk, .rst_n, .in_ch, .cfg_ch, .q_full, .q_push, .q_data
  );

  lrc_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_data), .full(q_full), .out_ch
  );

endmodule

// ----- rtl/lrc_checker.sv -----
module lrc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [7:0] data_byte,
  input logic       end_of_log
);

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> kind <= lrc_pkg::KIND_SIZE) else $error("kind out of range");
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != lrc_pkg::KIND_PAYLOAD |-> data_byte == 8'd0)
    else $error("data on non-payload");
  a_trunc_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == lrc_pkg::KIND_TRUNC |-> end_of_log)
    else $error("truncation without end");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("valid dropped");

endmodule

bind log_record_checker_crc32_unit lrc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .kind(out_ch.kind), .data_byte(out_ch.data_byte), .end_of_log(out_ch.end_of_log)
);

// ----- tb/log_record_checker_crc32_unit_tb.sv -----
`timescale 1ns / 100ps

module log_record_checker_crc32_unit_tb;

  typedef enum logic [1:0] {ST_HEADER, ST_PAYLOAD, ST_FOOTER} rec_state_t;

  logic clk;
  logic rst_n;

  lrc_in_if  in_ch();
  lrc_out_if out_ch();
  lrc_cfg_if cfg_ch();

  log_record_checker_crc32_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Register copies and record tracking state of the predictor.
  logic [31:0] m_start;
  logic [23:0] m_limit;
  logic [31:0] m_magic;
  logic        m_le;
  rec_state_t  m_state;
  logic [23:0] m_count;
  logic [31:0] m_magic_acc;
  logic [31:0] m_len_acc;
  logic [31:0] m_hdr_crc;
  logic [31:0] m_crc;
  logic [31:0] m_ftr_acc;
  logic [31:0] m_offset;
  logic [31:0] m_good_off;
  logic        m_halted;

  lrc_pkg::result_t pending_results[$];
  int          error_count;
  int          send_idle;
  int          recv_stall;
  int          bytes_sent;
  logic [7:0]  rec_bytes[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] v);
    logic [31:0] c;
    c = c_in ^ {24'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ 32'hEDB88320;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] shift_in(input logic [31:0] acc, input logic [7:0] v);
    if (m_le) begin
      return {v, acc[31:8]};
    end
    return {acc[23:0], v};
  endfunction

  task automatic model_reset();
    m_start = 32'd16;
    m_limit = 24'd65548;
    m_magic = 32'h43454C52;
    m_le = 1'b0;
    m_state = ST_HEADER;
    m_count = '0;
    m_crc = '1;
    m_magic_acc = '0;
    m_len_acc = '0;
    m_hdr_crc = '0;
    m_ftr_acc = '0;
    m_offset = m_start;
    m_good_off = m_start;
    m_halted = 1'b0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    int k;
    logic [7:0] d;
    logic lk;
    lrc_pkg::result_t r;
    k = -1;
    d = '0;
    lk = 1'b0;
    if (m_halted) return;
    if (m_offset == 32'hFFFFFFFF) begin
      k = lrc_pkg::KIND_SIZE;
      m_halted = 1'b1;
    end else begin
      m_offset = m_offset + 1;
      case (m_state)
        ST_HEADER: begin
          if (m_count == 0) begin
            m_magic_acc = '0;
            m_len_acc = '0;
            m_hdr_crc = '0;
          end
          if (m_count < 8) m_crc = crc_step(m_crc, b);
          if (m_count < 4) m_magic_acc = shift_in(m_magic_acc, b);
          else if (m_count < 8) m_len_acc = shift_in(m_len_acc, b);
          else m_hdr_crc = shift_in(m_hdr_crc, b);
          m_count = m_count + 1;
          if (m_count >= 12) begin
            if (m_magic_acc != m_magic || (m_crc ^ 32'hFFFFFFFF) != m_hdr_crc ||
                m_len_acc > {8'd0, m_limit}) begin
              k = lrc_pkg::KIND_BAD_HDR;
              lk = 1'b1;
              m_halted = 1'b1;
            end else begin
              m_state = (m_len_acc != 0) ? ST_PAYLOAD : ST_FOOTER;
              m_count = '0;
              m_crc = '1;
              m_ftr_acc = '0;
            end
          end
        end
        ST_PAYLOAD: begin
          m_crc = crc_step(m_crc, b);
          m_count = m_count + 1;
          k = lrc_pkg::KIND_PAYLOAD;
          d = b;
          if ({8'd0, m_count} >= m_len_acc) begin
            m_state = ST_FOOTER;
            m_count = '0;
            m_ftr_acc = '0;
          end
        end
        default: begin
          m_ftr_acc = shift_in(m_ftr_acc, b);
          m_count = m_count + 1;
          if (m_count >= 4) begin
            lk = 1'b1;
            if (m_ftr_acc == (m_crc ^ 32'hFFFFFFFF)) begin
              k = lrc_pkg::KIND_GOOD;
              m_good_off = m_offset;
              m_state = ST_HEADER;
              m_count = '0;
              m_crc = '1;
            end else begin
              k = lrc_pkg::KIND_CRC_ERR;
              m_halted = 1'b1;
            end
          end
        end
      endcase
    end
    if (last) begin
      if (k == -1 || k == lrc_pkg::KIND_PAYLOAD) begin
        k = lrc_pkg::KIND_TRUNC;
        d = '0;
      end
      m_halted = 1'b1;
    end
    if (k < 0) return;
    if (m_state != ST_HEADER) lk = 1'b1;
    r.kind = lrc_pkg::kind_t'(k);
    r.data_byte = d;
    r.record_length = lk ? m_len_acc[23:0] : 24'd0;
    r.good_offset = m_good_off;
    r.end_of_log = last;
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    lrc_pkg::result_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat kind", {29'd0, out_ch.kind}, 32'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_ch.kind != w.kind) report_mismatch("kind", out_ch.kind, w.kind);
        if (out_ch.data_byte != w.data_byte)
          report_mismatch("data_byte", out_ch.data_byte, w.data_byte);
        if (out_ch.record_length != w.record_length)
          report_mismatch("record_length", out_ch.record_length, w.record_length);
        if (out_ch.good_offset != w.good_offset)
          report_mismatch("good_offset", out_ch.good_offset, w.good_offset);
        if (out_ch.end_of_log != w.end_of_log)
          report_mismatch("end_of_log", out_ch.end_of_log, w.end_of_log);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.log_byte <= b;
    in_ch.last_of_log <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      lrc_pkg::REG_START: begin
        m_start = val;
        m_offset = val;
        m_good_off = val;
      end
      lrc_pkg::REG_LIMIT: m_limit = val[23:0];
      lrc_pkg::REG_MAGIC: m_magic = val;
      default: m_le = val[0];
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_word(input logic [31:0] v);
    for (int i = 0; i < 4; i++) begin
      if (m_le) rec_bytes.insert(rec_bytes.size(), v[8*i +: 8]);
      else rec_bytes.insert(rec_bytes.size(), v[8*(3-i) +: 8]);
    end
  endtask

  // Flaws: 0 none, 1 wrong magic, 2 wrong header CRC, 3 wrong footer CRC.
  task automatic build_record(input int len, input int flaw);
    logic [31:0] c;
    logic [7:0] v;
    rec_bytes.delete();
    push_word((flaw == 1) ? ~m_magic : m_magic);
    push_word(len);
    c = '1;
    for (int i = 0; i < 8; i++) c = crc_step(c, rec_bytes[i]);
    push_word((flaw == 2) ? c : ~c);
    c = '1;
    for (int i = 0; i < len; i++) begin
      v = $urandom_range(255);
      rec_bytes.insert(rec_bytes.size(), v);
      c = crc_step(c, v);
    end
    push_word((flaw == 3) ? c : ~c);
  endtask

  task automatic send_record(input int len, input int flaw, input logic end_log);
    build_record(len, flaw);
    foreach (rec_bytes[i]) send_byte(rec_bytes[i], end_log && (i == rec_bytes.size() - 1));
  endtask

  task automatic test_directed();
    send_idle = 8;
    recv_stall = 63;
    send_record(0, 0, 1'b0);
    send_record(1, 0, 1'b0);
    wait_drained();
    write_reg(lrc_pkg::REG_ORDER, 32'd1);
    write_reg(lrc_pkg::REG_MAGIC, 32'h00000000);
    write_reg(lrc_pkg::REG_LIMIT, 32'd0);
    send_record(0, 0, 1'b0);
    wait_drained();
    write_reg(lrc_pkg::REG_MAGIC, 32'hFFFFFFFF);
    write_reg(lrc_pkg::REG_LIMIT, 32'h00FFFFFF);
    write_reg(lrc_pkg::REG_START, 32'd0);
    send_record(3, 0, 1'b0);
    send_record(2, 0, 1'b0);
    wait_drained();
  endtask

  task automatic run_records(input int budget);
    int target;
    target = bytes_sent + budget;
    while (bytes_sent < target) begin
      if ($urandom_range(9) == 0) begin
        wait_drained();
        case ($urandom_range(3))
          0: write_reg(lrc_pkg::REG_START, $urandom_range(32'h7FFFFFFF));
          1: write_reg(lrc_pkg::REG_LIMIT,
                       $urandom_range(1) ? 32'h00FFFFFF : 32'd60 + $urandom_range(200));
          2: write_reg(lrc_pkg::REG_MAGIC, $urandom());
          default: write_reg(lrc_pkg::REG_ORDER, $urandom_range(1));
        endcase
      end
      send_record(($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12), 0, 1'b0);
    end
  endtask

  task automatic test_random();
    send_idle = 8;
    recv_stall = 63;
    run_records(260);
    send_idle = 63;
    recv_stall = 8;
    run_records(260);
    send_idle = 0;
    recv_stall = 0;
    run_records(260);
  endtask

  task automatic test_log_end();
    int mode;
    int cut;
    wait_drained();
    write_reg(lrc_pkg::REG_LIMIT, 32'd40);
    mode = $urandom_range(6);
    case (mode)
      0: send_record($urandom_range(20), 0, 1'b1);
      1: begin
        build_record(10 + $urandom_range(10), 0);
        cut = 1 + $urandom_range(rec_bytes.size() - 2);
        for (int i = 0; i < cut; i++) send_byte(rec_bytes[i], i == cut - 1);
      end
      2: send_record(5, 1, 1'b0);
      3: send_record(5, 2, 1'b0);
      4: send_record(41, 0, 1'b0);
      5: send_record(5, 3, 1'b0);
      default: begin
        write_reg(lrc_pkg::REG_START, 32'hFFFFFFFF - $urandom_range(20));
        send_record(20, 0, 1'b1);
      end
    endcase
    for (int i = 0; i < 3; i++) send_byte($urandom_range(255), $urandom_range(1));
    wait_drained();
  endtask

  initial begin
    error_count = 0;
    bytes_sent = 0;
    send_idle = 0;
    recv_stall = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.log_byte = '0;
    in_ch.last_of_log = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = lrc_pkg::REG_START;
    cfg_ch.data = '0;
    model_reset();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random();
    test_log_end();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
